// ===== hw/rtl/qrs_pkg.sv =====
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int CW     = 16;          // coefficient width
    localparam int RW     = 32;          // result width
    localparam int PW     = 2 * CW;      // product width
    localparam int DW     = PW + 2;      // signed discriminant width
    localparam int RADW   = 50;          // |d| << 16, even bit count
    localparam int ROOTW  = RADW / 2;    // square root width
    localparam int REMW   = ROOTW + 3;   // square root partial remainder
    localparam int NW     = ROOTW + 2;   // signed numerator width
    localparam int DVDW   = NW + 7;      // |n| * 128
    localparam int AMW    = CW;          // |a|, up to 2^(CW-1)
    localparam int DREMW  = AMW + 1;
    localparam int SQ_STAGES  = ROOTW;
    localparam int DIV_STAGES = DVDW;

    typedef enum logic [1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_REPEATED = 2'd1,
        KIND_COMPLEX  = 2'd2
    } root_kind_t;

endpackage

// ===== hw/rtl/quadratic_root_solver.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and m_tready is low.
// Reset: synchronous, active low on aresetn; clears every stage valid bit,
// payload registers are not reset.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] root_kind, [33:2] first_value, [65:34] second_value,
    // [66] zero_lead_error, [67] saturated, [71:68] zero
    output logic [71:0] m_tdata
);

    // Pipeline map:
    //   stage 1      : b*b and a*c (two 16x16 multipliers)
    //   stage 2      : discriminant, root kind, |d| << 16
    //   stages 3..27 : restoring square root, one result bit per stage
    //   stage 28     : numerators and their magnitudes / signs
    //   stages 29..62: two restoring dividers by |a|, one quotient bit each
    //   stage 63     : sign, saturation, output register
    // All stages move together; a full output register with m_tready low
    // freezes everything, so nothing is dropped or repeated.

    typedef struct packed {
        logic                    valid;
        logic signed [CW-1:0]    a;
        logic signed [CW-1:0]    b;
        logic signed [PW-1:0]    bb;
        logic signed [PW-1:0]    ac;
    } mul_t;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        root_kind_t              kind;
        logic signed [CW-1:0]    a;
        logic signed [CW-1:0]    b;
        logic [RADW-1:0]         rad;
        logic [REMW-1:0]         rem;
        logic [ROOTW-1:0]        root;
    } sq_t;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        root_kind_t              kind;
        logic [AMW-1:0]          am;
        logic                    neg1;
        logic                    neg2;
        logic [DVDW-1:0]         dvd1;
        logic [DVDW-1:0]         dvd2;
        logic [AMW-1:0]          rem1;
        logic [AMW-1:0]          rem2;
        logic [DVDW-1:0]         q1;
        logic [DVDW-1:0]         q2;
    } dv_t;

    logic adv;
    mul_t mul_reg, mul_next;
    sq_t  sq_reg [SQ_STAGES+1];     // entry 0: discriminant stage
    sq_t  sq_in  [SQ_STAGES+1];
    sq_t  sq_next[SQ_STAGES+1];
    dv_t  dv_reg [DIV_STAGES+1];    // entry 0: numerator stage
    dv_t  dv_in  [DIV_STAGES+1];
    dv_t  dv_next[DIV_STAGES+1];
    logic [71:0] out_reg, out_next;
    logic        out_valid_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    function automatic sq_t sq_step(sq_t x);
        sq_t                y;
        logic [REMW-1:0]    r;
        logic [REMW-1:0]    t;
        y = x;
        r = {x.rem[REMW-3:0], x.rad[RADW-1:RADW-2]};
        t = {{(REMW-ROOTW-2){1'b0}}, x.root, 2'b01};
        y.rad = {x.rad[RADW-3:0], 2'b00};
        if (r >= t) begin
            y.rem  = r - t;
            y.root = {x.root[ROOTW-2:0], 1'b1};
        end else begin
            y.rem  = r;
            y.root = {x.root[ROOTW-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [DREMW+DVDW-1:0] div_step(
        logic [AMW-1:0] rem, logic [DVDW-1:0] q, logic bitin, logic [AMW-1:0] am);
        logic [DREMW-1:0] r;
        logic             qb;
        r  = {rem, bitin};
        qb = (r >= {1'b0, am});
        if (qb) begin
            r = r - {1'b0, am};
        end
        return {r, q[DVDW-2:0], qb};
    endfunction

    // stage 1
    always_comb begin
        mul_next.valid = s_tvalid;
        mul_next.a     = s_tdata[15:0];
        mul_next.b     = s_tdata[31:16];
        mul_next.bb    = $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
        mul_next.ac    = $signed(s_tdata[15:0]) * $signed(s_tdata[47:32]);
    end

    // stage 2 and square root
    always_comb begin
        logic signed [DW-1:0] d;
        logic [DW-1:0]        dm;
        d  = {{2{mul_reg.bb[PW-1]}}, mul_reg.bb} - {mul_reg.ac, 2'b00};
        dm = d[DW-1] ? -d : d;
        sq_next[0].valid = mul_reg.valid;
        sq_next[0].zero  = (mul_reg.a == '0);
        sq_next[0].a     = mul_reg.a;
        sq_next[0].b     = mul_reg.b;
        sq_next[0].kind  = d[DW-1] ? KIND_COMPLEX :
                           (d == '0) ? KIND_REPEATED : KIND_DISTINCT;
        sq_next[0].rad   = {dm[RADW-17:0], 16'd0};
        sq_next[0].rem   = '0;
        sq_next[0].root  = '0;
        sq_in[0]         = sq_next[0];
        for (int k = 1; k <= SQ_STAGES; k++) begin
            sq_in[k]   = sq_reg[k-1];
            sq_next[k] = sq_step(sq_in[k]);
        end
    end

    // numerator stage and dividers
    always_comb begin
        sq_t                  s;
        logic signed [NW-1:0] nb;
        logic signed [NW-1:0] sr;
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
        logic [NW-1:0]        m1;
        logic [NW-1:0]        m2;
        logic [DREMW+DVDW-1:0] st;
        s  = sq_reg[SQ_STAGES];
        nb = -({{(NW-CW){s.b[CW-1]}}, s.b} <<< 8);
        sr = {2'b00, s.root};
        if (s.kind == KIND_COMPLEX) begin
            n1 = nb;
            n2 = sr;
        end else begin
            n1 = nb + sr;
            n2 = nb - sr;
        end
        m1 = n1[NW-1] ? -n1 : n1;
        m2 = n2[NW-1] ? -n2 : n2;
        dv_next[0].valid = s.valid;
        dv_next[0].zero  = s.zero;
        dv_next[0].kind  = s.kind;
        dv_next[0].am    = s.a[CW-1] ? AMW'(-s.a) : AMW'(s.a);
        dv_next[0].neg1  = n1[NW-1] ^ s.a[CW-1];
        dv_next[0].neg2  = n2[NW-1] ^ s.a[CW-1];
        dv_next[0].dvd1  = {m1, 7'd0};
        dv_next[0].dvd2  = {m2, 7'd0};
        dv_next[0].rem1  = '0;
        dv_next[0].rem2  = '0;
        dv_next[0].q1    = '0;
        dv_next[0].q2    = '0;
        dv_in[0]         = dv_next[0];
        for (int k = 1; k <= DIV_STAGES; k++) begin
            dv_in[k]   = dv_reg[k-1];
            dv_next[k] = dv_in[k];
            dv_next[k].dvd1 = {dv_in[k].dvd1[DVDW-2:0], 1'b0};
            dv_next[k].dvd2 = {dv_in[k].dvd2[DVDW-2:0], 1'b0};
            st = div_step(dv_in[k].rem1, dv_in[k].q1, dv_in[k].dvd1[DVDW-1], dv_in[k].am);
            dv_next[k].rem1 = st[AMW+DVDW-1:DVDW];
            dv_next[k].q1   = st[DVDW-1:0];
            st = div_step(dv_in[k].rem2, dv_in[k].q2, dv_in[k].dvd2[DVDW-1], dv_in[k].am);
            dv_next[k].rem2 = st[AMW+DVDW-1:DVDW];
            dv_next[k].q2   = st[DVDW-1:0];
        end
    end

    // sign, saturation, packing
    always_comb begin
        dv_t               f;
        logic [RW-1:0]     v1;
        logic [RW-1:0]     v2;
        logic              s1;
        logic              s2;
        logic [DVDW-1:0]   pmax;
        logic [DVDW-1:0]   nmax;
        f    = dv_reg[DIV_STAGES];
        pmax = DVDW'({1'b0, {(RW-1){1'b1}}});
        nmax = DVDW'({1'b1, {(RW-1){1'b0}}});
        if (f.neg1) begin
            s1 = f.q1 > nmax;
            v1 = s1 ? {1'b1, {(RW-1){1'b0}}} : RW'(-f.q1);
        end else begin
            s1 = f.q1 > pmax;
            v1 = s1 ? {1'b0, {(RW-1){1'b1}}} : RW'(f.q1);
        end
        if (f.neg2) begin
            s2 = f.q2 > nmax;
            v2 = s2 ? {1'b1, {(RW-1){1'b0}}} : RW'(-f.q2);
        end else begin
            s2 = f.q2 > pmax;
            v2 = s2 ? {1'b0, {(RW-1){1'b1}}} : RW'(f.q2);
        end
        if (f.zero) begin
            out_next = {4'd0, 1'b0, 1'b1, {RW{1'b0}}, {RW{1'b0}}, KIND_DISTINCT};
        end else begin
            out_next = {4'd0, s1 | s2, 1'b0, v2, v1, f.kind};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg.valid <= 1'b0;
            for (int k = 0; k <= SQ_STAGES; k++) begin
                sq_reg[k].valid <= 1'b0;
            end
            for (int k = 0; k <= DIV_STAGES; k++) begin
                dv_reg[k].valid <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_reg <= mul_next;
            for (int k = 0; k <= SQ_STAGES; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k <= DIV_STAGES; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            out_valid_reg <= dv_reg[DIV_STAGES].valid;
            out_reg       <= out_next;
        end
    end

endmodule

// ===== hw/rtl/qrs_checker.sv =====
`timescale 1ns / 1ps
module qrs_checker
    import qrs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // zero lead coefficient gives all-zero values
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66] |-> m_tdata[65:0] == '0 && !m_tdata[67])
        else $error("zero lead result not cleared");

    // repeated root reports one value twice
    a_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == KIND_REPEATED |-> m_tdata[33:2] == m_tdata[65:34])
        else $error("repeated root values differ");

    // no result right after reset
    a_rst: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // ready only when output side can move
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken during stall");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import qrs_pkg::*;

    // expected root record, laid out as m_tdata[67:0] (kind lowest)
    typedef struct packed {
        logic        clipped;
        logic        zero_lead;
        logic [31:0] x2;
        logic [31:0] x1;
        logic [1:0]  kind;
    } roots_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    roots_t      roots_q[$];
    int          errors;
    bit          rx_hold;   // when set, receiver never stalls
    int          gap_max;

    quadratic_root_solver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic longint isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint scale_clip(longint n, longint a, inout logic clip);
        longint q;
        q = (n * 128) / a;
        if (q > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return q;
    endfunction

    function automatic roots_t solve_roots(logic [15:0] ra, logic [15:0] rb,
                                           logic [15:0] rc);
        roots_t r;
        longint a, b, c, d, nb, s, v1, v2;
        logic clip;
        r = '0;
        clip = 1'b0;
        a = longint'($signed(ra));
        b = longint'($signed(rb));
        c = longint'($signed(rc));
        if (a == 0) begin
            r.zero_lead = 1'b1;
            return r;
        end
        d = b * b - 4 * a * c;
        nb = -b * 256;
        if (d > 0) begin
            s = isqrt64(d << 16);
            r.kind = KIND_DISTINCT;
            v1 = scale_clip(nb + s, a, clip);
            v2 = scale_clip(nb - s, a, clip);
        end else if (d == 0) begin
            r.kind = KIND_REPEATED;
            v1 = scale_clip(nb, a, clip);
            v2 = v1;
        end else begin
            s = isqrt64((-d) << 16);
            r.kind = KIND_COMPLEX;
            v1 = scale_clip(nb, a, clip);
            v2 = scale_clip(s, a, clip);
        end
        r.x1 = v1[31:0];
        r.x2 = v2[31:0];
        r.clipped = clip;
        return r;
    endfunction

    // drive one request; inputs move on the falling edge
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        roots_q.push_back(solve_roots(a, b, c));
        @(negedge aclk);
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 9) > 2);
    end

    // result checker
    always @(posedge aclk) begin
        roots_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[67:0];
            if (m_tdata[71:68] != 4'd0) begin
                errors++;
                $display("%0t: pad bits exp 0 got %h", $time, m_tdata[71:68]);
            end
            if (roots_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_tdata);
            end else begin
                want = roots_q.pop_front();
                if (got.kind != want.kind) begin
                    errors++;
                    $display("%0t: root_kind exp %0d got %0d", $time, want.kind, got.kind);
                end
                if (got.x1 != want.x1) begin
                    errors++;
                    $display("%0t: first_value exp %h got %h", $time, want.x1, got.x1);
                end
                if (got.x2 != want.x2) begin
                    errors++;
                    $display("%0t: second_value exp %h got %h", $time, want.x2, got.x2);
                end
                if (got.zero_lead != want.zero_lead) begin
                    errors++;
                    $display("%0t: zero_lead_error exp %0d got %0d", $time,
                             want.zero_lead, got.zero_lead);
                end
                if (got.clipped != want.clipped) begin
                    errors++;
                    $display("%0t: saturated exp %0d got %0d", $time,
                             want.clipped, got.clipped);
                end
            end
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 8) - 4);
            3: return 16'($urandom_range(0, 1024) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_edges();
        send_coefs(16'h0000, 16'h1234, 16'h5678);   // zero leading coef
        send_coefs(16'h0000, 16'h0000, 16'h0000);
        send_coefs(16'h0100, 16'hfd00, 16'h0200);   // x^2-3x+2
        send_coefs(16'h0100, 16'hfe00, 16'h0100);   // repeated root
        send_coefs(16'h0100, 16'h0000, 16'h0100);   // complex
        send_coefs(16'hff00, 16'h0000, 16'h0100);   // negative a, distinct
        send_coefs(16'h0001, 16'h7fff, 16'h0000);   // clipped
        send_coefs(16'h0001, 16'h8000, 16'h0000);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h8000, 16'h7fff, 16'h7fff);
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h0001, 16'h0000, 16'h8000);
        send_coefs(16'h0001, 16'h0000, 16'h7fff);   // complex, huge imag
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'h0002, 16'h0004, 16'h0002);   // repeated, tiny
        send_coefs(16'h0001, 16'h0002, 16'h0001);
    endtask

    task automatic test_random(int n);
        logic [15:0] a, b, c, k;
        for (int i = 0; i < n; i++) begin
            if (i % 200 == 0) gap_max = $urandom_range(0, 6);
            rx_hold = (i % 300) < 60;
            a = pick_coef();
            b = pick_coef();
            if ($urandom_range(0, 4) == 0) begin
                // aim at a repeated root: b = 2k, a = 1, c = k*k
                k = 16'($urandom_range(0, 60) - 30);
                a = 16'h0001;
                b = 16'(2 * $signed(k));
                c = 16'($signed(k) * $signed(k));
            end else begin
                c = pick_coef();
            end
            send_coefs(a, b, c);
        end
    endtask

    initial begin
        errors   = 0;
        gap_max  = 4;
        rx_hold  = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_edges();
        test_random(1100);
        s_tvalid <= 1'b0;
        while (roots_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (errors == 0) $display("** quadratic_root_solver: PASSED **");
        else $display("** quadratic_root_solver: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** quadratic_root_solver: FAILED **");
        $finish;
    end

endmodule
